// File: sv/gmps_pkg.sv
// Shared types and constants of the grid maximum path sum block.
package gmps_pkg;

   // Field and register widths.
   localparam int CELL_W      = 8;
   localparam int TOTAL_W     = 19;
   localparam int COLS_REG_W  = 7;
   localparam int ROWS_REG_W  = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 1'b1;

   // Register reset values.
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd64;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd1;

   // Largest total; sums saturate here.
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 19'h7FFFF;

   // Position flags that the front end attaches to each cell.
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic grid_end;
   } gmps_tag_type;

   localparam int TAG_W = $bits(gmps_tag_type);

endpackage

// File: sv/gmps_front.sv
// Front end: configuration registers, cell acceptance and grid position tracking.
module gmps_front import gmps_pkg::*; #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CELL_W-1:0]       req_cell_value,
   input  logic                    q_full,
   output logic                    q_push,
   output logic [CELL_W-1:0]       q_cell,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] q_col,
   output gmps_tag_type            q_tag
);

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [COLS_REG_W-1:0] cols_reg_ff, cols_reg_in;
   logic [ROWS_REG_W-1:0] rows_reg_ff, rows_reg_in;
   logic [CW-1:0]         column_index_ff, column_index_in;
   logic [RW-1:0]         row_index_ff, row_index_in;
   logic [CW:0]           cols_eff;
   logic [RW:0]           rows_eff;
   logic [CW:0]           col_plus_one;
   logic [RW:0]           row_plus_one;
   logic                  accept;
   logic                  last_col;
   logic                  last_row;

   // A word is taken whenever the queue has room.
   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign q_push    = accept;

   // Register writes.
   always_comb begin
      cols_reg_in = cols_reg_ff;
      rows_reg_in = rows_reg_ff;
      if (csr_write && (csr_index == CSR_COLUMN_COUNT)) begin
         cols_reg_in = csr_data[COLS_REG_W-1:0];
      end else if (csr_write && (csr_index == CSR_ROW_COUNT)) begin
         rows_reg_in = csr_data[ROWS_REG_W-1:0];
      end
   end

   // Counts in effect: zero acts as one, and the sizes of the design cap them.
   always_comb begin
      if (cols_reg_ff == '0) begin
         cols_eff = (CW+1)'(1);
      end else if (int'(cols_reg_ff) > MAX_COLS) begin
         cols_eff = (CW+1)'(MAX_COLS);
      end else begin
         cols_eff = (CW+1)'(cols_reg_ff);
      end
      if (rows_reg_ff == '0) begin
         rows_eff = (RW+1)'(1);
      end else if (int'(rows_reg_ff) > MAX_ROWS) begin
         rows_eff = (RW+1)'(MAX_ROWS);
      end else begin
         rows_eff = (RW+1)'(rows_reg_ff);
      end
   end

   // A row or grid ends when the next index reaches or passes the count.
   assign col_plus_one = {1'b0, column_index_ff} + (CW+1)'(1);
   assign row_plus_one = {1'b0, row_index_ff} + (RW+1)'(1);
   assign last_col     = col_plus_one >= cols_eff;
   assign last_row     = row_plus_one >= rows_eff;

   // Position of the next cell.
   always_comb begin
      column_index_in = column_index_ff;
      row_index_in    = row_index_ff;
      if (accept) begin
         if (last_col) begin
            column_index_in = '0;
            row_index_in    = last_row ? '0 : row_plus_one[RW-1:0];
         end else begin
            column_index_in = col_plus_one[CW-1:0];
         end
      end
   end

   // Classified word towards the back end.
   assign q_cell          = req_cell_value;
   assign q_col           = column_index_ff;
   assign q_tag.first_row = (row_index_ff == '0);
   assign q_tag.first_col = (column_index_ff == '0);
   assign q_tag.grid_end  = last_col && last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_reg_ff     <= COLS_RESET;
         rows_reg_ff     <= ROWS_RESET;
         column_index_ff <= '0;
         row_index_ff    <= '0;
      end else begin
         cols_reg_ff     <= cols_reg_in;
         rows_reg_ff     <= rows_reg_in;
         column_index_ff <= column_index_in;
         row_index_ff    <= row_index_in;
      end
   end

endmodule

// File: sv/gmps_queue.sv
// Two-entry queue that decouples the front end from the back end.
module gmps_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);

   localparam int DEPTH = 2;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/gmps_back.sv
// Back end: line buffer, best-total update and the result register.
module gmps_back import gmps_pkg::*; #(
   parameter int MAX_COLS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   output logic                    q_pop,
   input  logic [CELL_W-1:0]       q_cell,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] q_col,
   input  gmps_tag_type            q_tag,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [TOTAL_W-1:0]      rsp_best_total
);

   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [TOTAL_W-1:0] line_mem [MAX_COLS];

   logic               a_valid_ff, a_valid_in;
   logic [CELL_W-1:0]  a_cell_ff;
   logic [CW-1:0]      a_col_ff;
   gmps_tag_type       a_tag_ff;
   logic               fwd_ff, fwd_in;
   logic [TOTAL_W-1:0] rd_data_ff;
   logic [TOTAL_W-1:0] left_best_ff, left_best_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_best_total_ff, rsp_best_total_in;
   logic               a_done;
   logic [TOTAL_W-1:0] above;
   logic [TOTAL_W-1:0] base;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] best;

   // The cell in the work stage leaves unless its result has nowhere to go.
   assign a_done = a_valid_ff && (!a_tag_ff.grid_end || !rsp_valid_ff || !rsp_stall);
   assign q_pop  = !q_empty && (!a_valid_ff || a_done);

   // The previous cell writes its column at the edge this one reads; forward it.
   assign fwd_in = a_done && (q_col == a_col_ff);

   // Best total of the cell in the work stage.
   always_comb begin
      above = fwd_ff ? left_best_ff : rd_data_ff;
      if (a_tag_ff.first_row) begin
         base = a_tag_ff.first_col ? '0 : left_best_ff;
      end else if (a_tag_ff.first_col) begin
         base = above;
      end else begin
         base = (above > left_best_ff) ? above : left_best_ff;
      end
      sum  = {1'b0, base} + (TOTAL_W+1)'(a_cell_ff);
      best = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
   end

   // Stage, running value and result register updates.
   always_comb begin
      a_valid_in        = a_valid_ff;
      left_best_in      = left_best_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_best_total_in = rsp_best_total_ff;
      if (q_pop) begin
         a_valid_in = 1'b1;
      end else if (a_done) begin
         a_valid_in = 1'b0;
      end
      if (a_done) begin
         left_best_in = best;
      end
      if (a_done && a_tag_ff.grid_end) begin
         rsp_valid_in      = 1'b1;
         rsp_best_total_in = best;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Line buffer: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (a_done) begin
         line_mem[a_col_ff] <= best;
      end
      if (q_pop) begin
         rd_data_ff <= line_mem[q_col];
      end
   end

   // Payload of the work stage.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_cell_ff <= q_cell;
         a_col_ff  <= q_col;
         a_tag_ff  <= q_tag;
         fwd_ff    <= fwd_in;
      end
      rsp_best_total_ff <= rsp_best_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         left_best_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         left_best_ff <= left_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_total = rsp_best_total_ff;

endmodule

// File: sv/grid_max_path_sum.sv
// Top level of the grid maximum path sum block.
// Cells of a grid enter one word per cycle in row-major order, and one word is
// taken every cycle for as long as the result side keeps up; a grid's best
// right/down path total passes the queue, work stage and result register to
// the result channel once its last cell is taken, and the block is back at the
// top-left corner. The line buffer sets the rate: it has one read and one
// write port and serves one column per cycle; its read runs one stage ahead
// of the add and compare. It has no reset and no clearing pass, so the block
// takes cells straight after reset. The user must write column and row counts
// via the csr port only while the block is idle; it does not enforce this.
module grid_max_path_sum import gmps_pkg::*; #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CELL_W-1:0]       req_cell_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [TOTAL_W-1:0]      rsp_best_total
);

   localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DATA_W = CELL_W + CW + TAG_W;

   logic              enq_push;
   logic [CELL_W-1:0] enq_cell;
   logic [CW-1:0]     enq_col;
   gmps_tag_type      enq_tag;
   logic              q_full;
   logic              q_empty;
   logic              deq_pop;
   logic [DATA_W-1:0] deq_data;
   logic [CELL_W-1:0] deq_cell;
   logic [CW-1:0]     deq_col;
   gmps_tag_type      deq_tag;

   gmps_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_value (req_cell_value),
      .q_full         (q_full),
      .q_push         (enq_push),
      .q_cell         (enq_cell),
      .q_col          (enq_col),
      .q_tag          (enq_tag)
   );

   gmps_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (enq_push),
      .push_data ({enq_cell, enq_col, enq_tag}),
      .pop       (deq_pop),
      .pop_data  (deq_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {deq_cell, deq_col, deq_tag} = deq_data;

   gmps_back #(
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (deq_pop),
      .q_cell         (deq_cell),
      .q_col          (deq_col),
      .q_tag          (deq_tag),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_total (rsp_best_total)
   );

endmodule

// File: sv/gmps_checker.sv
// Port-level checks of the grid maximum path sum block and their binding.
module gmps_checker import gmps_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [TOTAL_W-1:0] rsp_best_total
);

   // A stalled result word stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_total))
      else $error("result word changed while stalled");

   // The input side only fills up after a word was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stall rose without an accepted word");

   // The queue only fills while a finished result waits on the output.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled while the result side was free");

   // A result needs work after reset before it can appear.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2))
      else $error("result appeared too soon after reset");

endmodule

bind grid_max_path_sum gmps_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_best_total (rsp_best_total)
);

// File: tb/tb_grid_max_path_sum.sv
// Self-checking testbench for the grid maximum path sum block.
module tb_grid_max_path_sum;
   timeunit 1ns;
   timeprecision 1ps;

   import gmps_pkg::*;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 1024;
   // A total follows its last cell through the block's registers; allow a margin.
   localparam int SETTLE_CYCLES = 8;
   // The slowest run is well under this: about a thousand cells, each at worst
   // waiting out the longest random gap on both sides, plus the long hold-off
   // and the register writes.
   localparam int LIMIT_CYCLES = 200_000;
   localparam int DRAIN_LIMIT = 10_000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_CELLS = 600;
   localparam int MAX_PRINTED = 100;

   // Corner grid of three by three: the best path runs down the first column
   // and then takes left over above along the last row.
   localparam logic [CELL_W-1:0] CROSS_GRID [9] = '{
      8'd10, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd200,
      8'd255, 8'd0, 8'd1
   };

   typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_MAX} fill_mode_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CELL_W-1:0]      req_cell_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [TOTAL_W-1:0]     rsp_best_total;

   // Stimulus and expected totals.
   logic [CELL_W-1:0]  cell_queue [$];
   logic [TOTAL_W-1:0] expected_totals [$];
   int unsigned        cells_queued = 0;
   int unsigned        cells_taken = 0;
   int unsigned        error_count = 0;
   int unsigned        cycle_count = 0;
   logic               req_taken = 1'b0;
   bit                 idle_on = 1'b1;
   bit                 hold_request = 1'b0;
   int unsigned        send_gap = 0;
   int unsigned        stall_left = 0;
   int unsigned        hold_left = 0;
   logic [TOTAL_W-1:0] oldest_total;

   // Predictor state: line buffer of best totals, running left total, position
   // and its own copy of the two count registers.
   logic [TOTAL_W-1:0]    line_best [MAX_COLS];
   bit                    line_set [MAX_COLS];
   logic [TOTAL_W-1:0]    left_total;
   logic [5:0]            col_pos;
   logic [9:0]            row_pos;
   logic [COLS_REG_W-1:0] col_count_reg;
   logic [ROWS_REG_W-1:0] row_count_reg;

   grid_max_path_sum uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_total (rsp_best_total)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // A count of zero behaves as one, and a count over the maximum as the maximum.
   function automatic int unsigned eff_count(input int unsigned value, input int unsigned hi);
      if (value == 0) begin
         return 1;
      end
      return (value > hi) ? hi : value;
   endfunction

   // Work out the best total at one cell and queue the grid total at its end.
   task automatic step_grid(input logic [CELL_W-1:0] coins);
      int unsigned        cols;
      int unsigned        rows;
      logic [TOTAL_W-1:0] above;
      logic [TOTAL_W-1:0] base;
      logic [TOTAL_W:0]   sum;
      logic [TOTAL_W-1:0] best;
      cols = eff_count(col_count_reg, MAX_COLS);
      rows = eff_count(row_count_reg, MAX_ROWS);
      above = line_best[col_pos];
      if (row_pos == 0) begin
         base = (col_pos == 0) ? '0 : left_total;
      end else if (col_pos == 0) begin
         base = above;
      end else begin
         base = (above > left_total) ? above : left_total;
      end
      sum = base + coins;
      best = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      line_best[col_pos] = best;
      line_set[col_pos] = 1'b1;
      left_total = best;
      if (col_pos + 1 >= cols) begin
         col_pos = '0;
         if (row_pos + 1 >= rows) begin
            expected_totals.push_back(best);
            row_pos = '0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endtask

   // Cells still needed, from the present position, to finish the grid.
   function automatic int unsigned cells_to_grid_end();
      int unsigned cols;
      int unsigned rows;
      int unsigned row_left;
      cols = eff_count(col_count_reg, MAX_COLS);
      rows = eff_count(row_count_reg, MAX_ROWS);
      row_left = (col_pos + 1 >= cols) ? 1 : cols - col_pos;
      if (row_pos + 1 >= rows) begin
         return row_left;
      end
      return row_left + (rows - row_pos - 1) * cols;
   endfunction

   // True when every line buffer entry below the count has been written.
   function automatic bit columns_ready(input int unsigned cols);
      for (int i = 0; i < cols; i++) begin
         if (!line_set[i]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // The column register is narrower than the data port; the spare bits get noise.
   task automatic set_shape(input int unsigned cols_value, input int unsigned rows_value);
      logic [CSR_DATA_W-1:0] col_word;
      col_word = CSR_DATA_W'($urandom());
      col_word[COLS_REG_W-1:0] = cols_value[COLS_REG_W-1:0];
      write_reg(CSR_COLUMN_COUNT, col_word);
      write_reg(CSR_ROW_COUNT, rows_value[ROWS_REG_W-1:0]);
   endtask

   // Queue words for the driver; done just after a rising edge, clear of the driver.
   task automatic queue_cells(input int unsigned count, input fill_mode_type fill);
      @(posedge clock);
      for (int unsigned i = 0; i < count; i++) begin
         case (fill)
            FILL_ZERO: cell_queue.push_back('0);
            FILL_MAX: cell_queue.push_back('1);
            default: cell_queue.push_back(CELL_W'($urandom()));
         endcase
      end
      cells_queued += count;
   endtask

   // Wait until every queued cell is taken and every total has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (cells_taken != cells_queued || expected_totals.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sender: a new word goes out once the last one was taken, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (cell_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_cell_value <= cell_queue.pop_front();
            if (idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 16);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, and one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: follows register writes and accepted cells, and checks each total.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         for (int i = 0; i < MAX_COLS; i++) begin
            line_best[i] = '0;
            line_set[i] = 1'b0;
         end
         left_total = '0;
         col_pos = '0;
         row_pos = '0;
         col_count_reg = COLS_RESET;
         row_count_reg = ROWS_RESET;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_COLUMN_COUNT) begin
               col_count_reg = csr_data[COLS_REG_W-1:0];
            end else if (csr_index == CSR_ROW_COUNT) begin
               row_count_reg = csr_data[ROWS_REG_W-1:0];
            end
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            cells_taken++;
            step_grid(req_cell_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_totals.size() == 0) begin
               report_error($sformatf("best_total %0d with no grid finished", rsp_best_total));
            end else begin
               oldest_total = expected_totals.pop_front();
               if (rsp_best_total !== oldest_total) begin
                  report_error($sformatf("best_total %0d, expected %0d",
                                         rsp_best_total, oldest_total));
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int unsigned   random_start;
      int unsigned   grids;
      int unsigned   cols_value;
      int unsigned   rows_value;
      int unsigned   pick;
      int unsigned   drain_count;
      fill_mode_type fill;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset counts: one row of sixty-four columns.
      queue_cells(cells_to_grid_end(), FILL_RANDOM);
      wait_idle();

      // Zero counts act as a single cell: the largest and the smallest word.
      set_shape(0, 0);
      queue_cells(1, FILL_MAX);
      queue_cells(1, FILL_ZERO);
      wait_idle();

      // Small grid where the path has to weigh above against left.
      set_shape(3, 3);
      @(posedge clock);
      foreach (CROSS_GRID[i]) begin
         cell_queue.push_back(CROSS_GRID[i]);
      end
      cells_queued += 9;
      wait_idle();

      // Counts changed mid-grid: the column index already lies past the new
      // column count, and the grid grows by two rows.
      set_shape(4, 3);
      queue_cells(6, FILL_RANDOM);
      wait_idle();
      set_shape(1, 5);
      queue_cells(cells_to_grid_end(), FILL_RANDOM);
      wait_idle();

      // Long hold-off on the result side while single-cell grids keep coming,
      // so that the block fills and stalls its input.
      set_shape(1, 1);
      @(posedge clock);
      idle_on = 1'b0;
      hold_request = 1'b1;
      queue_cells(60, FILL_RANDOM);
      wait_idle();

      // Random shapes, mostly small, with the odd wide or tall one.
      random_start = cells_queued;
      while (cells_queued - random_start < RANDOM_CELLS) begin
         pick = $urandom_range(0, 9);
         grids = $urandom_range(1, 4);
         if (pick == 0) begin
            cols_value = $urandom_range(0, 127);
            rows_value = $urandom_range(0, 3);
            grids = 1;
         end else if (pick == 1) begin
            cols_value = $urandom_range(0, 2);
            rows_value = $urandom_range(0, 40);
         end else begin
            cols_value = $urandom_range(1, 8);
            rows_value = $urandom_range(1, 8);
         end
         set_shape(cols_value, rows_value);
         @(posedge clock);
         idle_on = ($urandom_range(0, 3) != 0);
         for (int unsigned g = 0; g < grids; g++) begin
            pick = $urandom_range(0, 5);
            fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_MAX : FILL_RANDOM;
            queue_cells(cells_to_grid_end(), fill);
         end
         wait_idle();
         // Now and then stop part-way through a grid and change the counts.
         if ($urandom_range(0, 4) == 0 && cells_to_grid_end() > 1) begin
            queue_cells($urandom_range(1, cells_to_grid_end() - 1), FILL_RANDOM);
            wait_idle();
            cols_value = $urandom_range(0, 127);
            // More columns are only allowed where the line buffer already holds them.
            if (!columns_ready(eff_count(cols_value, MAX_COLS))) begin
               cols_value = $urandom_range(1, eff_count(col_count_reg, MAX_COLS));
            end
            set_shape(cols_value, $urandom_range(0, 12));
            queue_cells(cells_to_grid_end(), FILL_RANDOM);
            wait_idle();
         end
      end

      // Extreme counts with no idling: a column count over the maximum with
      // the largest word throughout, and a single widest row.
      @(posedge clock);
      idle_on = 1'b0;
      set_shape(127, 2);
      queue_cells(cells_to_grid_end(), FILL_MAX);
      wait_idle();
      set_shape(64, 0);
      queue_cells(cells_to_grid_end(), FILL_RANDOM);

      // Drain: every cell taken, then every total back, then a few more cycles.
      do @(negedge clock);
      while (cells_taken != cells_queued);
      drain_count = 0;
      while (expected_totals.size() != 0 && drain_count < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_count++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_totals.size() != 0) begin
         report_error($sformatf("%0d totals never arrived", expected_totals.size()));
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
